// ===== src/tba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tba_pkg: shared types and codes of the tile block allocator
// Field widths, command, operation and status codes, and the queue geometry.
// ----------------------------------------------------------------------------
package tba_pkg;

  localparam int CMD_W    = 2;
  localparam int BLK_W    = 10;
  localparam int SIZE_W   = 7;
  localparam int STATUS_W = 3;

  // Command field
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  // Classified operation
  typedef logic [1:0] op_t;
  localparam op_t OP_RESET  = 2'd0;
  localparam op_t OP_ALLOC  = 2'd1;
  localparam op_t OP_FREE   = 2'd2;
  localparam op_t OP_IGNORE = 2'd3;

  // Result status
  localparam logic [STATUS_W-1:0] ST_LIST    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BUMP    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WRAP    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RESET   = 3'd5;

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    op_t               op;
    logic              arena;
    logic [BLK_W-1:0]  blk;
    logic [SIZE_W-1:0] size;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    granted;
  } result_t;

endpackage

// ===== src/tile_block_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_block_allocator_unit: segregated free-list tile block allocator
// Two-arena allocator with per-size LIFO free lists and a bump pointer.
// ----------------------------------------------------------------------------
// One result beat leaves for every command beat, in order. A reset, an
// ignored command, a free onto an empty list and a bump-pointer allocate
// finish in the idle state of the back end; a free onto a non-empty list
// finishes in the read state and an allocate popped from a free list in the
// pop state after the read state: the registered read of the list-head RAM
// is followed by the registered read of the link RAM. A two-beat queue sits
// behind the input, so commands are taken while the back end works, and a
// finished result waits in an output register. List heads come up empty at
// reset through per-entry valid bits, so no clearing pass runs; the link
// table holds no reset value and is always written before it is followed.
module tile_block_allocator_unit import tba_pkg::*; #(
  parameter int ARENA_TILES   = 1024,
  parameter int MAX_LIST_SIZE = 64,
  parameter int ARENA_COUNT   = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    command,
  input  logic                arena,
  input  logic [BLK_W-1:0]    block_index,
  input  logic [SIZE_W-1:0]   size_tiles,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [BLK_W-1:0]    granted_block
);

  item_t   in_item;
  item_t   q_item;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  result_t res;

  // Classify the incoming beat.
  tba_front #(
    .ARENA_TILES   (ARENA_TILES),
    .MAX_LIST_SIZE (MAX_LIST_SIZE),
    .ARENA_COUNT   (ARENA_COUNT)
  ) u_front (
    .command     (command),
    .arena       (arena),
    .block_index (block_index),
    .size_tiles  (size_tiles),
    .item        (in_item)
  );

  // Hold classified beats until the back end takes them.
  assign in_ready = !q_full;

  tba_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_item (in_item),
    .full      (q_full),
    .valid     (q_valid),
    .item      (q_item),
    .pop       (q_pop)
  );

  // Carry out each command against the lists and bump pointers.
  tba_back #(
    .ARENA_TILES   (ARENA_TILES),
    .MAX_LIST_SIZE (MAX_LIST_SIZE),
    .ARENA_COUNT   (ARENA_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign status        = res.status;
  assign granted_block = res.granted;

endmodule

// ===== src/tba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tba_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module tba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tba_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tba_front: command classifier
// Fold the arena field onto the arenas present and sort each beat into
// reset, allocate, valid free or ignored.
// ----------------------------------------------------------------------------
module tba_front import tba_pkg::*; #(
  parameter int ARENA_TILES   = 1024,
  parameter int MAX_LIST_SIZE = 64,
  parameter int ARENA_COUNT   = 2
) (
  input  logic [CMD_W-1:0]  command,
  input  logic              arena,
  input  logic [BLK_W-1:0]  block_index,
  input  logic [SIZE_W-1:0] size_tiles,
  output item_t             item
);

  logic free_ok;

  assign free_ok = (size_tiles != '0) && (32'(size_tiles) <= MAX_LIST_SIZE) &&
                   (32'(block_index) < ARENA_TILES);

  always_comb begin
    item.arena = (ARENA_COUNT > 1) ? arena : 1'b0;
    item.blk   = block_index;
    item.size  = size_tiles;
    unique case (command)
      CMD_RESET: item.op = OP_RESET;
      CMD_ALLOC: item.op = OP_ALLOC;
      CMD_FREE:  item.op = free_ok ? OP_FREE : OP_IGNORE;
      default:   item.op = OP_IGNORE;
    endcase
  end

endmodule

// ===== src/tba_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tba_fifo: command queue
// Short queue of classified beats between the front and the back.
// ----------------------------------------------------------------------------
module tba_fifo import tba_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  valid,
  output item_t item,
  input  logic  pop
);

  item_t           store [Q_DEPTH];
  logic [Q_AW-1:0] wptr, wptr_next;
  logic [Q_AW-1:0] rptr, rptr_next;
  logic [Q_CW-1:0] count, count_next;

  assign full  = (count == Q_CW'(Q_DEPTH));
  assign valid = (count != '0);
  assign item  = store[rptr];

  always_comb begin
    wptr_next = wptr;
    rptr_next = rptr;
    if (push) begin
      wptr_next = (wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
    end
    if (pop) begin
      rptr_next = (rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr_next;
      rptr  <= rptr_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wptr] <= push_item;
    end
  end

endmodule

// ===== src/tba_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tba_back: allocator execution engine
// Sequence head and link RAM accesses, keep bump pointers and list valid
// bits, and hold each result in an output register.
// ----------------------------------------------------------------------------
module tba_back import tba_pkg::*; #(
  parameter int ARENA_TILES   = 1024,
  parameter int MAX_LIST_SIZE = 64,
  parameter int ARENA_COUNT   = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res
);

  localparam int AW     = $clog2(ARENA_TILES);
  localparam int PW     = $clog2(ARENA_TILES + 1);
  localparam int ARENAS = (ARENA_COUNT > 1) ? 2 : 1;
  localparam int SLOTS  = MAX_LIST_SIZE + 1;
  localparam int HDEPTH = ARENAS * SLOTS;
  localparam int HAW    = $clog2(HDEPTH);
  localparam int LDEPTH = ARENAS * ARENA_TILES;
  localparam int LAW    = $clog2(LDEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0]      state, state_next;
  item_t           cur;
  logic [AW-1:0]   cur_b;
  logic            out_valid_next;
  result_t         res_next;

  logic [HDEPTH-1:0] head_valid;
  logic [PW-1:0]     bump [ARENAS];

  item_t           sel;
  logic [HAW-1:0]  head_addr;
  logic            in_list;
  logic            head_hit;
  logic [PW-1:0]   cb;
  logic [PW:0]     sum_w;
  logic            wrap;
  logic [PW-1:0]   base;
  logic [PW-1:0]   bump_new;
  logic [LAW-1:0]  free_link_addr;
  logic [LAW-1:0]  pop_link_addr;

  logic            head_re, head_we;
  logic [AW-1:0]   head_wdata, head_rdata;
  logic            link_re, link_we;
  logic [AW:0]     link_wdata, link_rdata;

  logic            finish;
  logic            clr;
  logic            bwe;
  logic [PW-1:0]   bump_val;
  logic            vwe;
  logic            vdata;

  // In idle the queue head is the item at hand; later the captured one.
  assign sel = (state == S_IDLE) ? q_item : cur;

  always_comb begin
    head_addr = sel.arena ? HAW'(SLOTS) + HAW'(sel.size) : HAW'(sel.size);
    in_list   = (32'(sel.size) <= MAX_LIST_SIZE);
    head_hit  = in_list && head_valid[head_addr];
    cb = bump[0];
    if (ARENAS > 1 && sel.arena) begin
      cb = bump[ARENAS-1];
    end
    sum_w    = {1'b0, cb} + (PW+1)'(sel.size);
    wrap     = (sum_w > (PW+1)'(ARENA_TILES));
    base     = wrap ? '0 : cb;
    bump_new = base + PW'(sel.size);
    free_link_addr = sel.arena ? LAW'(ARENA_TILES) + LAW'(sel.blk) : LAW'(sel.blk);
    pop_link_addr  = cur.arena ? LAW'(ARENA_TILES) + LAW'(head_rdata) : LAW'(head_rdata);
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    head_re    = 1'b0;
    head_we    = 1'b0;
    head_wdata = AW'(sel.blk);
    link_re    = 1'b0;
    link_we    = 1'b0;
    link_wdata = {1'b1, head_rdata};
    finish     = 1'b0;
    clr        = 1'b0;
    bwe        = 1'b0;
    bump_val   = bump_new;
    vwe        = 1'b0;
    vdata      = 1'b1;
    res_next   = '{status: ST_IGNORED, granted: '0};
    unique case (state)
      S_IDLE: begin
        if (q_valid && (!out_valid || out_ready)) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            OP_RESET: begin
              clr      = 1'b1;
              bwe      = 1'b1;
              bump_val = '0;
              finish   = 1'b1;
              res_next = '{status: ST_RESET, granted: '0};
            end
            OP_ALLOC: begin
              if (head_hit) begin
                head_re    = 1'b1;
                state_next = S_READ;
              end else begin
                bwe      = 1'b1;
                finish   = 1'b1;
                res_next = '{status: wrap ? ST_WRAP : ST_BUMP, granted: BLK_W'(base)};
              end
            end
            OP_FREE: begin
              if (head_valid[head_addr]) begin
                head_re    = 1'b1;
                state_next = S_READ;
              end else begin
                // Empty list: the pushed block becomes the list end.
                link_we    = 1'b1;
                link_wdata = '0;
                head_we    = 1'b1;
                vwe        = 1'b1;
                finish     = 1'b1;
                res_next   = '{status: ST_FREED, granted: '0};
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (cur.op == OP_ALLOC) begin
          link_re    = 1'b1;
          state_next = S_POP;
        end else begin
          link_we    = 1'b1;
          head_we    = 1'b1;
          vwe        = 1'b1;
          finish     = 1'b1;
          res_next   = '{status: ST_FREED, granted: '0};
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        head_we    = 1'b1;
        head_wdata = link_rdata[AW-1:0];
        vwe        = 1'b1;
        vdata      = link_rdata[AW];
        finish     = 1'b1;
        res_next   = '{status: ST_LIST, granted: BLK_W'(cur_b)};
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      head_valid <= '0;
      for (int a = 0; a < ARENAS; a++) begin
        bump[a] <= '0;
      end
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (clr) begin
        for (int i = 0; i < HDEPTH; i++) begin
          if ((i >= SLOTS) == sel.arena) begin
            head_valid[i] <= 1'b0;
          end
        end
      end
      if (vwe) begin
        head_valid[head_addr] <= vdata;
      end
      for (int a = 0; a < ARENAS; a++) begin
        if (bwe && (a == int'(sel.arena))) begin
          bump[a] <= bump_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (state == S_READ) begin
      cur_b <= head_rdata;
    end
    if (finish) begin
      res <= res_next;
    end
  end

  tba_ram #(.WIDTH(AW), .DEPTH(HDEPTH)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_addr),
    .wdata (head_wdata),
    .re    (head_re),
    .raddr (head_addr),
    .rdata (head_rdata)
  );

  tba_ram #(.WIDTH(AW + 1), .DEPTH(LDEPTH)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (free_link_addr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (pop_link_addr),
    .rdata (link_rdata)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    finish |-> (!out_valid || out_ready))
    else $error("result written while output register still full");

  a_read_follows_head: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> $past(head_re))
    else $error("head data used without a head read");

  a_pop_from_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> ($past(state) == S_READ && cur.op == OP_ALLOC))
    else $error("list pop entered outside an allocate");

  a_link_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(link_we && link_re))
    else $error("link RAM read and written in one cycle");

endmodule
